[rtl/assert_macros.svh]
// Assertion macros shared by the list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define BVID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define BVID_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/bvid_pkg.sv]
// Package: widths, codes and payload types of the bounded list.
package bvid_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [2:0] ACT_READ   = 3'd0;
    localparam logic [2:0] ACT_APPEND = 3'd1;
    localparam logic [2:0] ACT_INSERT = 3'd2;
    localparam logic [2:0] ACT_POP    = 3'd3;
    localparam logic [2:0] ACT_DELETE = 3'd4;
    localparam logic [2:0] ACT_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT
    } cell_op_t;

    typedef struct packed {
        logic [2:0]               action;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]         count;
    } result_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } upd_t;

endpackage

[rtl/bvid_cell.sv]
// One storage cell of the list: hold, load, or take a neighbour's word.
module bvid_cell (
    input  logic                               clk,
    input  bvid_pkg::cell_op_t                 op,
    input  logic signed [bvid_pkg::DATA_W-1:0] load_data,
    input  logic signed [bvid_pkg::DATA_W-1:0] left_data,
    input  logic signed [bvid_pkg::DATA_W-1:0] right_data,
    output logic signed [bvid_pkg::DATA_W-1:0] data
);
    import bvid_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        unique case (op)
            CELL_LOAD:  data_next = load_data;
            CELL_LEFT:  data_next = left_data;
            CELL_RIGHT: data_next = right_data;
            CELL_HOLD:  data_next = data_reg;
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/bvid_ctrl.sv]
// Controller: element count, command checks and per-cell operations.
`include "assert_macros.svh"

module bvid_ctrl (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   go,
    input  bvid_pkg::cmd_t                         command,
    output bvid_pkg::upd_t                         upd,
    output bvid_pkg::cell_op_t [bvid_pkg::DEPTH-1:0] ops
);
    import bvid_pkg::*;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_APPEND,
        MODE_INSERT,
        MODE_DELETE
    } mode_t;

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] idx_ext;
    logic             idx_ok;
    logic             has_room;
    logic             is_empty;
    logic [1:0]       status;
    mode_t            mode;

    assign idx_ext  = CNT_W'(command.index);
    assign idx_ok   = idx_ext < fill_reg;
    assign has_room = fill_reg < CNT_W'(DEPTH);
    assign is_empty = fill_reg == '0;

    always_comb
    begin
        status    = ST_OK;
        mode      = MODE_NONE;
        fill_next = fill_reg;
        unique case (command.action)
            ACT_READ:
            begin
                if (!idx_ok)
                    status = ST_RANGE;
            end
            ACT_APPEND:
            begin
                if (!has_room)
                    status = ST_FULL;
                else
                begin
                    mode      = MODE_APPEND;
                    fill_next = fill_reg + 1'b1;
                end
            end
            ACT_INSERT:
            begin
                if (!idx_ok)
                    status = ST_RANGE;
                else if (!has_room)
                    status = ST_FULL;
                else
                begin
                    mode      = MODE_INSERT;
                    fill_next = fill_reg + 1'b1;
                end
            end
            ACT_POP:
            begin
                if (is_empty)
                    status = ST_EMPTY;
                else
                    fill_next = fill_reg - 1'b1;
            end
            ACT_DELETE:
            begin
                if (is_empty)
                    status = ST_EMPTY;
                else if (!idx_ok)
                    status = ST_RANGE;
                else
                begin
                    mode      = MODE_DELETE;
                    fill_next = fill_reg - 1'b1;
                end
            end
            ACT_CLEAR:
                fill_next = '0;
            default:
                status = ST_OK;
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_op
        localparam logic [CNT_W-1:0] POS = CNT_W'(i);
        always_comb
        begin
            ops[i] = CELL_HOLD;
            if (go)
            begin
                case (mode)
                    MODE_APPEND:
                        if (POS == fill_reg)
                            ops[i] = CELL_LOAD;
                    MODE_INSERT:
                        if (POS == idx_ext)
                            ops[i] = CELL_LOAD;
                        else if (POS > idx_ext && POS <= fill_reg)
                            ops[i] = CELL_LEFT;
                    MODE_DELETE:
                        if (POS >= idx_ext && (POS + 1'b1) < fill_reg)
                            ops[i] = CELL_RIGHT;
                    default:
                        ops[i] = CELL_HOLD;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (go)
            fill_reg <= fill_next;
    end

    assign upd.status = status;
    assign upd.count  = fill_next;

    `BVID_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CNT_W'(DEPTH), "count beyond depth")
    `BVID_ASSERT(a_reject_keeps_fill, (status != ST_OK) |-> (fill_next == fill_reg && mode == MODE_NONE), "rejected command alters the list")
    `BVID_ASSERT(a_step_one, (go && command.action != ACT_CLEAR) |=> (fill_reg == $past(fill_reg) || fill_reg == $past(fill_reg) + 1'b1 || fill_reg == $past(fill_reg) - 1'b1), "count moved by more than one")

endmodule

[rtl/bounded_vector_insert_delete.sv]
// Top level: bounded ordered list of signed words held in a row of cells.
// Latency: the result is strobed on done in the cycle after start is taken.
// Throughput: one command per cycle; every cell shifts, loads or holds at once.
// busy stays low, since each command finishes in the cycle it is taken.
// Reset clears the element count and the done strobe; cell contents are kept.
`include "assert_macros.svh"

module bounded_vector_insert_delete (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bvid_pkg::cmd_t    command,
    output logic              done,
    output bvid_pkg::result_t result
);
    import bvid_pkg::*;

    logic                              go;
    upd_t                              upd;
    cell_op_t [DEPTH-1:0]              ops;
    logic signed [DATA_W-1:0]          cell_data [DEPTH];
    logic signed [DATA_W-1:0]          rd;
    logic                              done_reg;
    result_t                           result_reg;

    assign busy = 1'b0;
    assign go   = start && !busy;

    bvid_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .command (command),
        .upd     (upd),
        .ops     (ops)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_in;
        logic signed [DATA_W-1:0] right_in;
        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[i+1];
        end

        bvid_cell u_cell (
            .clk        (clk),
            .op         (ops[i]),
            .load_data  (command.value),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

    assign rd = (command.action == ACT_READ && upd.status == ST_OK)
              ? cell_data[command.index] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= go;
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            result_reg.status    <= upd.status;
            result_reg.read_data <= rd;
            result_reg.count     <= upd.count;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `BVID_ASSERT(a_done_follows, go |=> done, "accepted transaction gave no result")
    `BVID_ASSERT(a_no_spurious, !go |=> !done, "result without a transaction")
    `BVID_ASSERT(a_rd_zero, (done && (result.status != ST_OK)) |-> (result.read_data == '0), "read data on a failed transaction")

endmodule

[bench/tb_bounded_vector_insert_delete.sv]
// Testbench for the bounded list: directed and random commands against a local list model.
module tb_bounded_vector_insert_delete;
    timeunit 1ns;
    timeprecision 1ps;

    import bvid_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    command;
    logic    done;
    result_t result;

    logic signed [DATA_W-1:0] list_mem [DEPTH];
    logic [CNT_W-1:0]         list_len;
    result_t                  expected_results [$];
    int                       items_taken;
    int                       fail_count;
    bit                       gaps_on;

    bounded_vector_insert_delete dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic result_t list_apply(cmd_t c);
        result_t r;
        int      i;
        r.status    = ST_OK;
        r.read_data = '0;
        case (c.action)
            ACT_READ:
            begin
                if (c.index < list_len)
                    r.read_data = list_mem[c.index];
                else
                    r.status = ST_RANGE;
            end
            ACT_APPEND:
            begin
                if (list_len >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = c.value;
                    list_len = list_len + 1'b1;
                end
            end
            ACT_INSERT:
            begin
                if (c.index >= list_len)
                    r.status = ST_RANGE;
                else if (list_len >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > c.index; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[c.index] = c.value;
                    list_len = list_len + 1'b1;
                end
            end
            ACT_POP:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    list_len = list_len - 1'b1;
            end
            ACT_DELETE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (c.index >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = c.index + 1; i < list_len; i++)
                        list_mem[i-1] = list_mem[i];
                    list_len = list_len - 1'b1;
                end
            end
            ACT_CLEAR:
                list_len = '0;
            default:
                ;
        endcase
        r.count = list_len;
        return r;
    endfunction

    // check the strobe of the cycle just ended, then take the new transaction
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: status %0d read_data %0d count %0d",
                                 result.status, result.read_data, result.count);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result.status !== exp_r.status || result.read_data !== exp_r.read_data
                        || result.count !== exp_r.count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch (exp/got): st %0d/%0d rd %0d/%0d cnt %0d/%0d",
                                     exp_r.status, result.status, exp_r.read_data,
                                     result.read_data, exp_r.count, result.count);
                    end
                end
            end
            if (start && !busy)
            begin
                expected_results = {expected_results, list_apply(command)};
                items_taken++;
            end
        end
    end

    task automatic send_cmd(input logic [2:0] act, input logic [IDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] val);
        int seen;
        while (gaps_on && $urandom_range(0, 99) < 29)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        command <= '{action: act, index: idx, value: val};
        seen = items_taken;
        do @(negedge clk); while (items_taken == seen);
    endtask

    task automatic drain_results();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < 100)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (4) @(negedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_list();
        send_cmd(ACT_READ, 4'd0, 32'sd1);
        send_cmd(ACT_READ, 4'd15, 32'sd2);
        send_cmd(ACT_POP, 4'd0, 32'sd0);
        send_cmd(ACT_DELETE, 4'd0, 32'sd0);
        send_cmd(ACT_DELETE, 4'd15, 32'sd0);
        send_cmd(ACT_INSERT, 4'd0, 32'sd7);
        send_cmd(ACT_SPARE_LO, 4'd5, 32'sd9);
        send_cmd(ACT_SPARE_HI, 4'd10, -32'sd9);
        send_cmd(ACT_CLEAR, 4'd3, 32'sd0);
        drain_results();
    endtask

    task automatic test_full_list();
        logic signed [DATA_W-1:0] w;
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i)
                0: w = 32'sh8000_0000;
                1: w = 32'sh7fff_ffff;
                2: w = '0;
                3: w = -1;
                4: w = 32'sh5555_5555;
                5: w = 32'shaaaa_aaaa;
                default: w = $urandom;
            endcase
            send_cmd(ACT_APPEND, IDX_W'(i), w);
        end
        send_cmd(ACT_APPEND, 4'd0, 32'sd11);
        send_cmd(ACT_INSERT, 4'd0, 32'sd12);
        send_cmd(ACT_INSERT, 4'd15, 32'sd13);
        send_cmd(ACT_READ, 4'd15, 32'sd0);
        send_cmd(ACT_READ, 4'd0, 32'sd0);
        send_cmd(ACT_DELETE, 4'd15, 32'sd0);
        send_cmd(ACT_DELETE, 4'd0, 32'sd0);
        send_cmd(ACT_READ, 4'd0, 32'sd0);
        send_cmd(ACT_INSERT, 4'd15, 32'sd14);
        send_cmd(ACT_DELETE, 4'd14, 32'sd0);
        send_cmd(ACT_INSERT, 4'd5, 32'sh1234_5678);
        send_cmd(ACT_READ, 4'd5, 32'sd0);
        send_cmd(ACT_POP, 4'd0, 32'sd0);
        send_cmd(ACT_CLEAR, 4'd0, 32'sd0);
        send_cmd(ACT_READ, 4'd0, 32'sd0);
        drain_results();
    endtask

    task automatic test_random_mix();
        int         len;
        int         roll;
        bit         grow;
        logic [2:0] act;
        logic [IDX_W-1:0] idx;
        grow = 1'b1;
        for (int n = 0; n < 520; n++)
        begin
            gaps_on = !(n >= 180 && n < 300);
            len = list_len;
            if (len == DEPTH)
                grow = 1'b0;
            else if (len == 0)
                grow = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                act = grow ? ACT_READ : ACT_CLEAR;
            else if (roll < 4)
                act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
            else if (roll < 18)
                act = ACT_READ;
            else if (roll < (grow ? 72 : 36))
                act = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
            else
                act = $urandom_range(0, 1) ? ACT_POP : ACT_DELETE;
            if (len > 0 && $urandom_range(0, 99) < 85)
                idx = IDX_W'($urandom_range(0, len - 1));
            else
                idx = IDX_W'($urandom_range(0, DEPTH - 1));
            send_cmd(act, idx, pick_word());
        end
        gaps_on = 1'b1;
        drain_results();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = '0;
        list_len    = '0;
        items_taken = 0;
        fail_count  = 0;
        gaps_on     = 1'b1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_list();
        test_full_list();
        test_random_mix();
        if (expected_results.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/bvid_pkg.sv
rtl/bvid_cell.sv
rtl/bvid_ctrl.sv
rtl/bounded_vector_insert_delete.sv
bench/tb_bounded_vector_insert_delete.sv
